// File: rtl/core/efi_pkg.sv
package efi_pkg;

    // Default sizing
    localparam int SOURCE_SAMPLES_DEF = 121;
    localparam int FRACTION_BITS_DEF  = 8;

    // Field widths
    localparam int COORD_W = 15;
    localparam int STEP_W  = 9;
    localparam int RATIO_W = 17;
    localparam int HALF_W  = 13;
    localparam int ADS_W   = 32;
    localparam int AMP_W   = 16;
    localparam int WGT_W   = 16;
    localparam int WIDX_W  = 8;
    localparam int ACC_W   = 63;
    localparam int VIS_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 80;

    localparam logic [ACC_W-1:0] SAT63 = {ACC_W{1'b1}};

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(26);
    localparam logic [AMP_W-1:0]  AMP_RST  = AMP_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JAW_RATIO     = 3'd0,
        CFG_HALF_JAW_X    = 3'd1,
        CFG_HALF_JAW_Y    = 3'd2,
        CFG_AXIS_DIST_SQ  = 3'd3,
        CFG_INV_SQUARE_ON = 3'd4,
        CFG_SOURCE_STEP   = 3'd5,
        CFG_AMPLITUDE     = 3'd6,
        CFG_GEOMETRY_OK   = 3'd7
    } cfg_idx_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_GEO,
        ST_TEST,
        ST_DECIDE,
        ST_DIV,
        ST_NEXT,
        ST_SCALE_INIT,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic calc_s;
        logic calc_geo;
        logic calc_test;
        logic add_direct;
        logic div_start;
        logic div_step;
        logic add_div;
        logic count_inc;
        logic advance;
        logic scale_start;
        logic scale_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic geom_valid;
        logic inv_on;
        logic visible;
        logic last_sample;
        logic div_done;
        logic scale_done;
    } sts_t;

    // Saturating add of two values that are each at most 2^63-1
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[ACC_W] ? SAT63 : sum[ACC_W-1:0];
    endfunction

endpackage

// File: rtl/core/efi_ctrl.sv
module efi_ctrl
    import efi_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_op,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // Sequence one request through the sample walk
    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_op == OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = sts.geom_valid ? ST_ADDR : ST_SCALE_INIT;
                    end
                end
            end
            ST_ADDR: begin
                cmd.calc_s = 1'b1;
                state_next = ST_GEO;
            end
            ST_GEO: begin
                cmd.calc_geo = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST: begin
                cmd.calc_test = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_NEXT;
                if (sts.visible) begin
                    cmd.count_inc = 1'b1;
                    if (sts.inv_on) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        cmd.add_direct = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.add_div = 1'b1;
                    state_next  = ST_NEXT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_NEXT: begin
                cmd.advance = 1'b1;
                state_next  = sts.last_sample ? ST_SCALE_INIT : ST_ADDR;
            end
            ST_SCALE_INIT: begin
                cmd.scale_start = 1'b1;
                state_next      = ST_SCALE;
            end
            ST_SCALE: begin
                if (sts.scale_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.scale_step = 1'b1;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/efi_dpath.sv
module efi_dpath
    import efi_pkg::*;
#(
    parameter int SOURCE_SAMPLES = SOURCE_SAMPLES_DEF,
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  cmd_t                      cmd,
    input  logic [WIDX_W-1:0]         weight_index,
    input  logic [WGT_W-1:0]          weight_value,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    output sts_t                      sts,
    output logic [ACC_W-1:0]          fluence,
    output logic [VIS_W-1:0]          visible_samples
);

    localparam int IDX_W   = $clog2(SOURCE_SAMPLES);
    localparam int OFF_W   = IDX_W + 1;
    localparam int CENTER  = (SOURCE_SAMPLES - 1) / 2;
    localparam int SX_W    = OFF_W + STEP_W + 1;
    localparam int DX_W    = ((SX_W > COORD_W) ? SX_W : COORD_W) + 1;
    localparam int JP_W    = RATIO_W + 1 + DX_W;
    localparam int J_W     = ((SX_W + 16 > JP_W) ? SX_W + 16 : JP_W) + 1;
    localparam int SQ_W    = 2 * DX_W;
    localparam int R2_W    = ((SQ_W > ADS_W) ? SQ_W : ADS_W) + 2;
    localparam int P1_W    = AMP_W + WGT_W;
    localparam int NUM_W   = AMP_W + 2 * WGT_W;
    localparam int SH      = 2 * FRACTION_BITS - 8;
    localparam int DIV_W   = NUM_W + SH;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int Q_EXT_W = (DIV_W > 64) ? DIV_W : 64;
    localparam int CNT_W   = $clog2(SOURCE_SAMPLES * SOURCE_SAMPLES + 1);
    localparam int STEP2_W = 2 * STEP_W;
    localparam int PROD_W  = ACC_W + STEP2_W;
    localparam int SCNT_W  = $clog2(STEP2_W + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOURCE_SAMPLES - 1);

    // Configuration registers
    logic [RATIO_W-1:0] jaw_ratio_reg;
    logic [HALF_W-1:0]  half_x_reg, half_y_reg;
    logic [ADS_W-1:0]   ads_reg;
    logic               inv_on_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic               geom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jaw_ratio_reg <= '0;
            half_x_reg    <= '0;
            half_y_reg    <= '0;
            ads_reg       <= '0;
            inv_on_reg    <= 1'b1;
            step_reg      <= STEP_RST;
            amp_reg       <= AMP_RST;
            geom_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_JAW_RATIO:     jaw_ratio_reg <= cfg_data[RATIO_W-1:0];
                CFG_HALF_JAW_X:    half_x_reg    <= cfg_data[HALF_W-1:0];
                CFG_HALF_JAW_Y:    half_y_reg    <= cfg_data[HALF_W-1:0];
                CFG_AXIS_DIST_SQ:  ads_reg       <= cfg_data[ADS_W-1:0];
                CFG_INV_SQUARE_ON: inv_on_reg    <= cfg_data[0];
                CFG_SOURCE_STEP:   step_reg      <= cfg_data[STEP_W-1:0];
                CFG_AMPLITUDE:     amp_reg       <= cfg_data[AMP_W-1:0];
                CFG_GEOMETRY_OK:   geom_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Weight table: one write port, two registered read ports
    logic [WGT_W-1:0] weight_mem [SOURCE_SAMPLES];
    logic [WGT_W-1:0] wx_reg, wy_reg;
    logic [IDX_W-1:0] ix_reg, iy_reg;
    logic             idx_ok;

    assign idx_ok = (9'(weight_index) < 9'(SOURCE_SAMPLES));

    always_ff @(posedge aclk) begin
        if (cmd.load && idx_ok) begin
            weight_mem[weight_index[IDX_W-1:0]] <= weight_value;
        end
        wx_reg <= weight_mem[ix_reg];
        wy_reg <= weight_mem[iy_reg];
    end

    // Grid counters and point latch
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      last_sample;

    assign last_sample = (ix_reg == LAST_IDX) && (iy_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ix_reg    <= '0;
            iy_reg    <= '0;
            count_reg <= '0;
        end else if (cmd.start) begin
            ix_reg    <= '0;
            iy_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.count_inc) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.advance) begin
                if (iy_reg == LAST_IDX) begin
                    iy_reg <= '0;
                    ix_reg <= (ix_reg == LAST_IDX) ? '0 : ix_reg + IDX_W'(1);
                end else begin
                    iy_reg <= iy_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
    end

    // Source coordinates
    logic signed [OFF_W-1:0]  off_x, off_y;
    logic signed [STEP_W:0]   step_s;
    logic signed [SX_W-1:0]   sx_reg, sy_reg;

    assign off_x  = $signed({1'b0, ix_reg}) - $signed(OFF_W'(CENTER));
    assign off_y  = $signed({1'b0, iy_reg}) - $signed(OFF_W'(CENTER));
    assign step_s = $signed({1'b0, step_reg});

    always_ff @(posedge aclk) begin
        if (cmd.calc_s) begin
            sx_reg <= SX_W'(off_x) * SX_W'(step_s);
            sy_reg <= SX_W'(off_y) * SX_W'(step_s);
        end
    end

    // Ray offsets, jaw products, squares, first weight product
    logic signed [DX_W-1:0]  dx_n, dy_n;
    logic signed [RATIO_W:0] ratio_s;
    logic signed [JP_W-1:0]  jpx_reg, jpy_reg;
    logic [SQ_W-1:0]         dx2_reg, dy2_reg;
    logic [P1_W-1:0]         prod1_reg;

    assign dx_n    = DX_W'(px_reg) - DX_W'(sx_reg);
    assign dy_n    = DX_W'(py_reg) - DX_W'(sy_reg);
    assign ratio_s = $signed({1'b0, jaw_ratio_reg});

    always_ff @(posedge aclk) begin
        if (cmd.calc_geo) begin
            jpx_reg   <= JP_W'(ratio_s) * JP_W'(dx_n);
            jpy_reg   <= JP_W'(ratio_s) * JP_W'(dy_n);
            dx2_reg   <= $unsigned(SQ_W'(dx_n) * SQ_W'(dx_n));
            dy2_reg   <= $unsigned(SQ_W'(dy_n) * SQ_W'(dy_n));
            prod1_reg <= P1_W'(amp_reg) * P1_W'(wx_reg);
        end
    end

    // Jaw test, squared ray length, full numerator
    logic signed [J_W-1:0] jx_s, jy_s;
    logic [J_W-1:0]        jx_abs, jy_abs, lim_x, lim_y;
    logic                  visible_reg;
    logic [R2_W-1:0]       r2_reg;
    logic [NUM_W-1:0]      num_reg;

    assign jx_s   = (J_W'(sx_reg) <<< 16) + J_W'(jpx_reg);
    assign jy_s   = (J_W'(sy_reg) <<< 16) + J_W'(jpy_reg);
    assign jx_abs = jx_s[J_W-1] ? $unsigned(-jx_s) : $unsigned(jx_s);
    assign jy_abs = jy_s[J_W-1] ? $unsigned(-jy_s) : $unsigned(jy_s);
    assign lim_x  = J_W'({half_x_reg, 16'h0000});
    assign lim_y  = J_W'({half_y_reg, 16'h0000});

    always_ff @(posedge aclk) begin
        if (cmd.calc_test) begin
            visible_reg <= (jx_abs <= lim_x) && (jy_abs <= lim_y);
            r2_reg      <= R2_W'(dx2_reg) + R2_W'(dy2_reg) + R2_W'(ads_reg);
            num_reg     <= NUM_W'(prod1_reg) * NUM_W'(wy_reg);
        end
    end

    // Restoring divider, one quotient bit per cycle
    logic [R2_W-1:0]   rem_reg, den_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [R2_W:0]     trial, trial_diff;
    logic              trial_ge;
    logic [Q_EXT_W-1:0] q_ext;
    logic [ACC_W-1:0]  div_term;

    assign trial      = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};
    assign q_ext      = Q_EXT_W'(quo_reg);
    assign div_term   = (|q_ext[Q_EXT_W-1:ACC_W]) ? SAT63 : q_ext[ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            rem_reg  <= '0;
            quo_reg  <= DIV_W'(num_reg) << SH;
            den_reg  <= (r2_reg == '0) ? R2_W'(1) : r2_reg;
            dcnt_reg <= DCNT_W'(DIV_W);
        end else if (cmd.div_step) begin
            rem_reg  <= trial_ge ? trial_diff[R2_W-1:0] : trial[R2_W-1:0];
            quo_reg  <= {quo_reg[DIV_W-2:0], trial_ge};
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    // Accumulator
    logic [ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.start) begin
            acc_reg <= '0;
        end else if (cmd.add_direct) begin
            acc_reg <= sat_add(acc_reg, ACC_W'(num_reg >> 8));
        end else if (cmd.add_div) begin
            acc_reg <= sat_add(acc_reg, div_term);
        end
    end

    // Shift-add scaling by step squared
    logic [STEP2_W-1:0] step2;
    logic [PROD_W-1:0]  mcand_reg, prod_reg;
    logic [STEP2_W-1:0] mplier_reg;
    logic [SCNT_W-1:0]  scnt_reg;

    assign step2 = STEP2_W'(step_reg) * STEP2_W'(step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scnt_reg <= '0;
        end else if (cmd.scale_start) begin
            mcand_reg  <= PROD_W'(acc_reg);
            mplier_reg <= step2;
            prod_reg   <= '0;
            scnt_reg   <= SCNT_W'(STEP2_W);
        end else if (cmd.scale_step) begin
            if (mplier_reg[0]) begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            scnt_reg   <= scnt_reg - SCNT_W'(1);
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            fluence         <= (|prod_reg[PROD_W-1:ACC_W]) ? SAT63 : prod_reg[ACC_W-1:0];
            visible_samples <= VIS_W'(count_reg);
        end
    end

    // Status to the controller
    always_comb begin
        sts.geom_valid  = geom_reg;
        sts.inv_on      = inv_on_reg;
        sts.visible     = visible_reg;
        sts.last_sample = last_sample;
        sts.div_done    = (dcnt_reg == '0);
        sts.scale_done  = (scnt_reg == '0);
    end

endmodule

// File: rtl/core/extra_focal_fluence_integrator.sv
// Load request: written to the weight table, no result.
// Compute request: a start, then per source sample the address, geometry,
// test, decide and next steps, plus the divider loop for a visible sample with
// inverse square on (all skipped if geometry is invalid); then shift-add scaling
// by step squared and the output step. One request is in work at a time.
// Reset (synchronous, active low) clears control, counters, accumulator, config.
module extra_focal_fluence_integrator
    import efi_pkg::*;
#(
    parameter int SOURCE_SAMPLES = SOURCE_SAMPLES_DEF,
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // weight_index[7:0], weight_value[23:8], point_x[38:24], point_y[53:39]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // op[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // fluence[62:0], visible_samples[79:63]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t             cmd;
    sts_t             sts;
    logic [ACC_W-1:0] fluence;
    logic [VIS_W-1:0] visible_samples;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {visible_samples, fluence};

    efi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    efi_dpath #(
        .SOURCE_SAMPLES (SOURCE_SAMPLES),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .weight_index    (s_tdata[7:0]),
        .weight_value    (s_tdata[23:8]),
        .point_x         ($signed(s_tdata[38:24])),
        .point_y         ($signed(s_tdata[53:39])),
        .sts             (sts),
        .fluence         (fluence),
        .visible_samples (visible_samples)
    );

endmodule

// File: rtl/core/efi_checker.sv
module efi_checker
    import efi_pkg::*;
#(
    parameter int SOURCE_SAMPLES = SOURCE_SAMPLES_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [0:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [VIS_W-1:0] MAX_VIS = VIS_W'(SOURCE_SAMPLES * SOURCE_SAMPLES);

    // Reset empties the output register
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Visible count never exceeds the grid size
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[79:63] <= MAX_VIS)
        else $error("visible count above grid size");

    // No visible sample means no fluence
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[79:63] == '0 |-> m_tdata[62:0] == '0)
        else $error("fluence without visible samples");

    // A table load produces no result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == OP_LOAD && !m_tvalid |=> !m_tvalid)
        else $error("result after table load");

endmodule

bind extra_focal_fluence_integrator efi_checker #(
    .SOURCE_SAMPLES (SOURCE_SAMPLES)
) u_efi_checker (.*);

// File: tb/sv/extra_focal_fluence_integrator_test.sv
`timescale 1ns / 100ps

module extra_focal_fluence_integrator_test;
    import efi_pkg::*;

    localparam int  SAMPLES  = SOURCE_SAMPLES_DEF;
    localparam int  CENTER   = (SAMPLES - 1) / 2;
    localparam int  DIV_SH   = 2 * FRACTION_BITS_DEF - 8;
    localparam int  STALL_LIMIT = 5_000_000;
    localparam longint unsigned FLU_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [VIS_W-1:0] visible;
        logic [ACC_W-1:0] fluence;
    } fluence_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow copy of the block's registers and weight table
    logic [RATIO_W-1:0] jaw_ratio;
    logic [HALF_W-1:0]  half_x, half_y;
    logic [ADS_W-1:0]   axis_dist_sq;
    logic               inv_square_on;
    logic [STEP_W-1:0]  grid_step;
    logic [AMP_W-1:0]   amp;
    logic               geom_ok;
    logic [WGT_W-1:0]   weight_mirror [SAMPLES];

    fluence_result_t pending_fluence [$];
    bit     quiet_mode;
    int     mismatches;
    int     points_sent, loads_sent, results_seen;
    longint stall_cycles;

    extra_focal_fluence_integrator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // jaw test for one axis, exact integer compare
    function automatic bit seen_through_jaw(input longint s, input longint p,
                                            input logic [HALF_W-1:0] half);
        longint j;
        j = s * 65536 + longint'(jaw_ratio) * (p - s);
        if (j < 0) j = -j;
        return j <= longint'(half) * 65536;
    endfunction

    function automatic longint unsigned add_clamped(input longint unsigned a,
                                                    input longint unsigned b);
        return (b > FLU_MAX - a) ? FLU_MAX : a + b;
    endfunction

    // walk the source grid for one isocenter point
    function automatic fluence_result_t integrate_point(input logic signed [COORD_W-1:0] px,
                                                        input logic signed [COORD_W-1:0] py);
        fluence_result_t res;
        longint unsigned acc, num, term, r2, step2;
        longint sx, sy, dx, dy;
        int cnt;
        acc = 0;
        cnt = 0;
        if (geom_ok) begin
            for (int ix = 0; ix < SAMPLES; ix++) begin
                sx = longint'(ix - CENTER) * longint'(grid_step);
                if (!seen_through_jaw(sx, px, half_x)) continue;
                for (int iy = 0; iy < SAMPLES; iy++) begin
                    sy = longint'(iy - CENTER) * longint'(grid_step);
                    if (!seen_through_jaw(sy, py, half_y)) continue;
                    cnt++;
                    num = longint'(amp) * weight_mirror[ix] * weight_mirror[iy];
                    if (inv_square_on) begin
                        dx = px - sx;
                        dy = py - sy;
                        r2 = dx * dx + dy * dy + longint'(axis_dist_sq);
                        if (r2 == 0) r2 = 1;
                        term = (num << DIV_SH) / r2;
                    end else begin
                        term = num >> 8;
                    end
                    acc = add_clamped(acc, term);
                end
            end
        end
        step2 = longint'(grid_step) * grid_step;
        if (step2 != 0 && acc > FLU_MAX / step2) res.fluence = FLU_MAX[ACC_W-1:0];
        else res.fluence = ACC_W'(acc * step2);
        res.visible = VIS_W'(cnt);
        return res;
    endfunction

    // result sink stalls at random unless quiet
    always @(negedge aclk) begin
        m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 19);
    end

    // compare each result against the oldest prediction
    always @(posedge aclk) begin
        fluence_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[ACC_W+VIS_W-1:0];
            results_seen++;
            if (pending_fluence.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result fluence=%0d visible=%0d",
                         $time, got.fluence, got.visible);
            end else begin
                want = pending_fluence.pop_front();
                if (got.fluence !== want.fluence) begin
                    mismatches++;
                    $display("%0t: fluence expected %0d actual %0d",
                             $time, want.fluence, got.fluence);
                end
                if (got.visible !== want.visible) begin
                    mismatches++;
                    $display("%0t: visible_samples expected %0d actual %0d",
                             $time, want.visible, got.visible);
                end
            end
        end
    end

    // count cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_fluence.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // send one request; predict at acceptance
    task automatic send_request(input logic op, input logic [WIDX_W-1:0] idx,
                                input logic [WGT_W-1:0] wval,
                                input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        @(negedge aclk);
        while (!quiet_mode && $urandom_range(99) < 19) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, py, px, wval, idx};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_COMPUTE) begin
            pending_fluence.push_back(integrate_point(px, py));
            points_sent++;
        end else begin
            loads_sent++;
            if (idx < SAMPLES) weight_mirror[idx] = wval;
        end
    endtask

    task automatic load_weight(input int idx, input logic [WGT_W-1:0] wval);
        send_request(OP_LOAD, WIDX_W'(idx), wval, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic compute_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        send_request(OP_COMPUTE, WIDX_W'($urandom), WGT_W'($urandom), px, py);
    endtask

    // drain results, then let a trailing load settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_fluence.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_JAW_RATIO:     jaw_ratio     = value[RATIO_W-1:0];
            CFG_HALF_JAW_X:    half_x        = value[HALF_W-1:0];
            CFG_HALF_JAW_Y:    half_y        = value[HALF_W-1:0];
            CFG_AXIS_DIST_SQ:  axis_dist_sq  = value;
            CFG_INV_SQUARE_ON: inv_square_on = value[0];
            CFG_SOURCE_STEP:   grid_step     = value[STEP_W-1:0];
            CFG_AMPLITUDE:     amp           = value[AMP_W-1:0];
            CFG_GEOMETRY_OK:   geom_ok       = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_geometry(input int ratio, input int hx, input int hy,
                                  input longint ads, input bit inv, input int step,
                                  input int amplitude_q88);
        wait_idle();
        write_reg(CFG_JAW_RATIO, ratio);
        write_reg(CFG_HALF_JAW_X, hx);
        write_reg(CFG_HALF_JAW_Y, hy);
        write_reg(CFG_AXIS_DIST_SQ, CFG_DATA_W'(ads));
        write_reg(CFG_INV_SQUARE_ON, CFG_DATA_W'(inv));
        write_reg(CFG_SOURCE_STEP, step);
        write_reg(CFG_AMPLITUDE, amplitude_q88);
        write_reg(CFG_GEOMETRY_OK, 1);
    endtask

    // fill the table, extremes at both ends and center; ignored indices too
    task automatic test_table_fill();
        quiet_mode = 1'b1;
        for (int i = 0; i < SAMPLES; i++) begin
            if (i == 0 || i == CENTER) load_weight(i, 16'hFFFF);
            else if (i == SAMPLES - 1) load_weight(i, 16'h0000);
            else load_weight(i, WGT_W'($urandom));
        end
        load_weight(SAMPLES, 16'h1234);
        load_weight(255, 16'hFFFF);
        quiet_mode = 1'b0;
    endtask

    // registers at reset leave geometry invalid: zero result
    task automatic test_degenerate_geometry();
        compute_point(15'h3FFF, 15'h4000);
        compute_point(15'h0000, 15'h0000);
    endtask

    // narrow jaws, inverse square, extreme points
    task automatic test_inverse_square();
        write_geometry(32768, 40, 40, 32'd1_000_000, 1, 26, 256);
        compute_point(15'h0000, 15'h0000);
        compute_point(15'h3FFF, 15'h3FFF);
        compute_point(15'h4000, 15'h4000);
        compute_point(15'h0030, 15'h7FD0);
    endtask

    // only the center sample is seen; the ray length is zero for the first point
    task automatic test_zero_ray_length();
        write_geometry(0, 0, 0, 0, 1, 1, 65535);
        compute_point(15'h0000, 15'h0000);
        write_geometry(0, 0, 0, 32'hFFFF_FFFF, 1, 1, 0);
        compute_point(15'h0000, 15'h0000);
    endtask

    // wide open, no inverse square, step 256: product saturates; ratio above one
    task automatic test_wide_open();
        write_geometry(65536, 8191, 8191, 0, 0, 256, 65535);
        compute_point(15'h1000, 15'h7000);
        write_geometry(131071, 8191, 8191, 0, 0, 256, 65535);
        compute_point(15'h0100, 15'h0100);
    endtask

    // zero pitch collapses the grid to the center
    task automatic test_zero_step();
        write_geometry(20000, 100, 100, 5, 0, 0, 300);
        compute_point(15'h0000, 15'h0000);
        compute_point(15'h0500, 15'h7F00);
    endtask

    // random settings per phase, reloads and points in between
    task automatic test_random_mix();
        bit inv;
        int nloads;
        for (int phase = 0; phase < 12; phase++) begin
            inv = $urandom_range(1);
            // keep the divider busy on only a few samples when inverse square is on
            if (inv)
                write_geometry($urandom_range(32768), $urandom_range(64), $urandom_range(64),
                               longint'($urandom), 1, $urandom_range(256, 32), $urandom);
            else
                write_geometry($urandom_range(131071), $urandom_range(8191),
                               $urandom_range(8191), longint'($urandom), 0,
                               $urandom_range(256, 1), $urandom);
            quiet_mode = (phase == 5);
            nloads = $urandom_range(3, 1);
            for (int k = 0; k < nloads; k++) begin
                if ($urandom_range(9) == 0)
                    load_weight($urandom_range(255, SAMPLES), WGT_W'($urandom));
                else
                    load_weight($urandom_range(SAMPLES - 1), WGT_W'($urandom));
            end
            compute_point(COORD_W'($urandom), COORD_W'($urandom));
            quiet_mode = 1'b0;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_JAW_RATIO;
        cfg_data = '0;
        quiet_mode = 1'b0;
        mismatches = 0;
        points_sent = 0;
        loads_sent = 0;
        results_seen = 0;
        stall_cycles = 0;
        jaw_ratio = '0;
        half_x = '0;
        half_y = '0;
        axis_dist_sq = '0;
        inv_square_on = 1'b1;
        grid_step = STEP_RST;
        amp = AMP_RST;
        geom_ok = 1'b0;
        foreach (weight_mirror[i]) weight_mirror[i] = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        test_table_fill();
        test_degenerate_geometry();
        test_inverse_square();
        test_zero_ray_length();
        test_wide_open();
        test_zero_step();
        test_random_mix();
        wait_idle();

        $display("Covered %0d weight loads and %0d point integrations, %0d results checked",
                 loads_sent, points_sent, results_seen);
        $display("Settings swept: invalid geometry, zero ray, saturation, zero pitch, random");
        if (mismatches == 0 && pending_fluence.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/efi_pkg.sv
rtl/core/efi_ctrl.sv
rtl/core/efi_dpath.sv
rtl/core/extra_focal_fluence_integrator.sv
rtl/core/efi_checker.sv
tb/sv/extra_focal_fluence_integrator_test.sv
